>>> hw/rtl/htm_pkg.sv
package htm_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int DIM_W      = 11;
   localparam int ADDR_W     = 20;
   localparam int FRAC_BITS  = 16;
   localparam int NUM_CH     = 3;
   localparam int CSR_IDX_W  = 2;

   localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = DIM_W'(1024);
   localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = DIM_W'(1024);
   localparam logic [DIM_W-1:0] WIDTH_LIMIT        = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] HEIGHT_LIMIT       = DIM_W'(MAX_HEIGHT);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic signed [11:0] pixel_x;
      logic signed [11:0] pixel_y;
      logic signed [31:0] red_linear;
      logic signed [31:0] green_linear;
      logic signed [31:0] blue_linear;
   } req_beat_type;

   typedef struct packed {
      logic [19:0] word_address;
      logic [23:0] packed_pixel;
   } rsp_beat_type;

endpackage

>>> hw/rtl/hdr_tone_map_pixel_writer_top.sv
// channel | direction | handshake            | beat
// req     | in        | start && !busy       | req_data (coordinate + RGB Q16.16)
// rsp     | out       | rsp_valid (strobe)   | rsp_data (word address + RGB888)
// csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// One pixel per clock; the pipeline is an input register, 16 radix-2
// divider stages, 16 one-digit square-root stages and the x255 output stage.
// busy never rises and csr_ready is always high.
// Synchronous reset clears the valid bits and sets both frame registers to 1024.
// The receiver cannot stall; an out-of-frame pixel enters as a bubble.
module hdr_tone_map_pixel_writer_top
   import htm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_beat_type       req_data,
   output logic               rsp_valid,
   output rsp_beat_type       rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]   csr_data
);

   localparam int DIV_END = FRAC_BITS;          // last divider stage
   localparam int SQ_END  = 2 * FRAC_BITS;      // last root stage
   localparam int LAST    = SQ_END + 1;         // output stage

   logic [DIM_W-1:0] frame_width_ff, frame_height_ff;
   logic [DIM_W-1:0] width_lim, height_lim;
   logic             in_frame, accept;

   logic             vld_ff  [LAST+1];
   logic [ADDR_W-1:0] addr_ff [LAST+1];

   logic [DIM_W-1:0] x0_ff, y0_ff, w0_ff;
   logic [31:0]      c0_ff [NUM_CH];

   // divider: partial remainder, divisor, quotient
   logic [31:0]      dv_rem_ff [DIV_END+1][NUM_CH];
   logic [31:0]      dv_d_ff   [DIV_END+1][NUM_CH];
   logic [15:0]      dv_q_ff   [DIV_END+1][NUM_CH];

   // square root: remainder, root, remaining radicand bits
   logic [17:0]      sq_rem_ff  [SQ_END+1][NUM_CH];
   logic [15:0]      sq_root_ff [SQ_END+1][NUM_CH];
   logic [31:0]      sq_n_ff    [SQ_END+1][NUM_CH];

   logic [7:0]       pix_ff [NUM_CH];

   logic signed [31:0] chan_in [NUM_CH];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   assign chan_in[0] = req_data.red_linear;
   assign chan_in[1] = req_data.green_linear;
   assign chan_in[2] = req_data.blue_linear;

   assign width_lim  = (frame_width_ff > WIDTH_LIMIT) ? WIDTH_LIMIT : frame_width_ff;
   assign height_lim = (frame_height_ff > HEIGHT_LIMIT) ? HEIGHT_LIMIT : frame_height_ff;

   assign in_frame = !req_data.pixel_x[11] && !req_data.pixel_y[11] &&
                     (req_data.pixel_x[DIM_W-1:0] < width_lim) &&
                     (req_data.pixel_y[DIM_W-1:0] < height_lim);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p <= LAST; p++) vld_ff[p] <= 1'b0;
      end else begin
         vld_ff[0] <= accept && in_frame;
         for (int p = 1; p <= LAST; p++) vld_ff[p] <= vld_ff[p-1];
      end
   end

   // datapath, free running
   always_ff @(posedge clock) begin
      logic [32:0] r2;
      logic [19:0] s2;
      logic [17:0] trial;
      logic [23:0] prod;
      logic [21:0] addr_full;

      x0_ff <= req_data.pixel_x[DIM_W-1:0];
      y0_ff <= req_data.pixel_y[DIM_W-1:0];
      w0_ff <= width_lim;
      for (int c = 0; c < NUM_CH; c++)
         c0_ff[c] <= (chan_in[c] <= 0) ? 32'd0 : chan_in[c];

      addr_full = 22'(y0_ff * w0_ff) + 22'(x0_ff);
      addr_ff[0] <= '0;
      addr_ff[1] <= addr_full[ADDR_W-1:0];
      for (int p = 2; p <= LAST; p++) addr_ff[p] <= addr_ff[p-1];

      for (int c = 0; c < NUM_CH; c++) begin
         dv_rem_ff[0][c] <= '0;
         dv_d_ff[0][c]   <= '0;
         dv_q_ff[0][c]   <= '0;
         // first divider step straight from the input register
         r2 = {c0_ff[c], 1'b0};
         if (r2 >= {1'b0, 32'(c0_ff[c] + 32'h10000)}) begin
            dv_rem_ff[1][c] <= 32'(r2 - {1'b0, 32'(c0_ff[c] + 32'h10000)});
            dv_q_ff[1][c]   <= 16'd1;
         end else begin
            dv_rem_ff[1][c] <= r2[31:0];
            dv_q_ff[1][c]   <= 16'd0;
         end
         dv_d_ff[1][c] <= c0_ff[c] + 32'h10000;

         for (int k = 2; k <= DIV_END; k++) begin
            r2 = {dv_rem_ff[k-1][c], 1'b0};
            if (r2 >= {1'b0, dv_d_ff[k-1][c]}) begin
               dv_rem_ff[k][c] <= 32'(r2 - {1'b0, dv_d_ff[k-1][c]});
               dv_q_ff[k][c]   <= {dv_q_ff[k-1][c][14:0], 1'b1};
            end else begin
               dv_rem_ff[k][c] <= r2[31:0];
               dv_q_ff[k][c]   <= {dv_q_ff[k-1][c][14:0], 1'b0};
            end
            dv_d_ff[k][c] <= dv_d_ff[k-1][c];
         end

         for (int j = 0; j <= DIV_END; j++) begin
            sq_rem_ff[j][c]  <= '0;
            sq_root_ff[j][c] <= '0;
            sq_n_ff[j][c]    <= '0;
         end
         // radicand is t << 16; two bits per stage, MSB first
         for (int j = DIV_END + 1; j <= SQ_END; j++) begin
            if (j == DIV_END + 1) begin
               s2    = {18'd0, dv_q_ff[DIV_END][c][15:14]};
               trial = 18'd1;
               sq_n_ff[j][c] <= {dv_q_ff[DIV_END][c][13:0], 18'd0};
            end else begin
               s2    = {sq_rem_ff[j-1][c], sq_n_ff[j-1][c][31:30]};
               trial = {sq_root_ff[j-1][c], 2'b01};
               sq_n_ff[j][c] <= {sq_n_ff[j-1][c][29:0], 2'b00};
            end
            if (s2 >= {2'b00, trial}) begin
               sq_rem_ff[j][c]  <= 18'(s2 - {2'b00, trial});
               sq_root_ff[j][c] <= (j == DIV_END + 1) ? 16'd1 :
                                   {sq_root_ff[j-1][c][14:0], 1'b1};
            end else begin
               sq_rem_ff[j][c]  <= s2[17:0];
               sq_root_ff[j][c] <= (j == DIV_END + 1) ? 16'd0 :
                                   {sq_root_ff[j-1][c][14:0], 1'b0};
            end
         end

         // s * 255 = (s << 8) - s, keep the integer part
         prod = {sq_root_ff[SQ_END][c], 8'd0} - {8'd0, sq_root_ff[SQ_END][c]};
         pix_ff[c] <= prod[23:16];
      end
   end

   assign rsp_valid              = vld_ff[LAST];
   assign rsp_data.word_address  = addr_ff[LAST];
   assign rsp_data.packed_pixel  = {pix_ff[0], pix_ff[1], pix_ff[2]};

   a_drop_out_of_frame: assert property (@(posedge clock) disable iff (reset)
      (accept && !in_frame) |=> !vld_ff[0])
      else $error("out-of-frame pixel entered the pipeline");

   a_no_bubble_loss: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] |-> ##LAST rsp_valid)
      else $error("pipeline lost a valid beat");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DIV_END] |-> (dv_rem_ff[DIV_END][0] < dv_d_ff[DIV_END][0]) &&
                          (dv_rem_ff[DIV_END][2] < dv_d_ff[DIV_END][2]))
      else $error("divider remainder out of range");

endmodule

>>> bench/hdr_tone_map_pixel_writer_top_tb.sv
`timescale 1ns / 1ps

module hdr_tone_map_pixel_writer_top_tb;
   import htm_pkg::*;

   localparam int PIPE_LATENCY = 34;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   req_beat_type       req_data;
   logic               rsp_valid;
   rsp_beat_type       rsp_data;
   logic               csr_valid;
   logic               csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DIM_W-1:0]   csr_data;

   hdr_tone_map_pixel_writer_top uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // shadow of the frame registers
   logic [DIM_W-1:0] width_shadow;
   logic [DIM_W-1:0] height_shadow;

   rsp_beat_type pixel_queue[$];
   int           mismatch_count;
   int           sender_idle_pct;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic logic [31:0] floor_sqrt(logic [31:0] n);
      logic [31:0] root;
      logic [31:0] bitv;
      root = 0;
      bitv = 32'h4000_0000;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n    = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic logic [7:0] tone_channel(logic signed [31:0] c);
      logic [63:0] cu;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] v;
      if (c <= 0) return 8'd0;
      cu = {32'd0, c};
      t  = (cu << 16) / (64'd65536 + cu);
      s  = {32'd0, floor_sqrt(32'(t << 16))};
      v  = (s * 64'd255) >> 16;
      if (v > 64'd255) v = 64'd255;
      return v[7:0];
   endfunction

   task automatic predict_pixel(input req_beat_type px);
      int           w;
      int           h;
      int           x;
      int           y;
      rsp_beat_type exp_pix;
      w = (width_shadow > WIDTH_LIMIT) ? MAX_WIDTH : int'(width_shadow);
      h = (height_shadow > HEIGHT_LIMIT) ? MAX_HEIGHT : int'(height_shadow);
      x = px.pixel_x;
      y = px.pixel_y;
      if (x < 0 || x >= w || y < 0 || y >= h) return;
      exp_pix.word_address = 20'(y * w + x);
      exp_pix.packed_pixel = {tone_channel(px.red_linear), tone_channel(px.green_linear),
                              tone_channel(px.blue_linear)};
      pixel_queue.push_back(exp_pix);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pixel_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected pixel: addr=%0d pix=%06h", rsp_data.word_address,
                        rsp_data.packed_pixel);
         end else begin
            rsp_beat_type exp_pix;
            exp_pix = pixel_queue.pop_front();
            if (exp_pix.word_address !== rsp_data.word_address) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("word_address: expected %0d, got %0d", exp_pix.word_address,
                           rsp_data.word_address);
            end
            if (exp_pix.packed_pixel !== rsp_data.packed_pixel) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("packed_pixel: expected %06h, got %06h", exp_pix.packed_pixel,
                           rsp_data.packed_pixel);
            end
         end
      end
   end

   task automatic send_pixel(input req_beat_type px);
      while (sender_idle_pct > 0 && $urandom_range(99, 0) < sender_idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start    = 1'b1;
      req_data = px;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_pixel(px);
      @(negedge clock);
      start = 1'b0;
   endtask

   // wait for every expected pixel, then let the pipe drain
   task automatic drain_pipe();
      while (pixel_queue.size() != 0) @(negedge clock);
      repeat (PIPE_LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_frame_reg(input csr_index_type idx, input logic [DIM_W-1:0] val);
      drain_pipe();
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_FRAME_WIDTH) width_shadow = val;
      else height_shadow = val;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic signed [31:0] rand_radiance();
      case ($urandom_range(5, 0))
         0: return $urandom;
         1: return -$signed({1'b0, 31'($urandom)});
         2: return $urandom_range(32'h0004_0000, 0);
         3: return $urandom_range(32'h0000_0200, 1);
         default: return $urandom_range(32'h7FFF_FFFF, 32'h0001_0000);
      endcase
   endfunction

   function automatic req_beat_type rand_pixel(input bit in_frame);
      req_beat_type px;
      int           w;
      int           h;
      w = (width_shadow > WIDTH_LIMIT) ? MAX_WIDTH : int'(width_shadow);
      h = (height_shadow > HEIGHT_LIMIT) ? MAX_HEIGHT : int'(height_shadow);
      if (in_frame && w > 0 && h > 0) begin
         px.pixel_x = 12'($urandom_range(w - 1, 0));
         px.pixel_y = 12'($urandom_range(h - 1, 0));
      end else begin
         px.pixel_x = 12'($urandom);
         px.pixel_y = 12'($urandom);
      end
      px.red_linear   = rand_radiance();
      px.green_linear = rand_radiance();
      px.blue_linear  = rand_radiance();
      return px;
   endfunction

   function automatic req_beat_type make_pixel(input int x, input int y,
                                               input logic [31:0] r, input logic [31:0] g,
                                               input logic [31:0] b);
      req_beat_type px;
      px.pixel_x      = 12'(x);
      px.pixel_y      = 12'(y);
      px.red_linear   = r;
      px.green_linear = g;
      px.blue_linear  = b;
      return px;
   endfunction

   task automatic test_directed_extremes();
      send_pixel(make_pixel(0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000));
      send_pixel(make_pixel(1023, 1023, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000));
      send_pixel(make_pixel(-1, 5, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
      send_pixel(make_pixel(5, -1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
      send_pixel(make_pixel(1024, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
      send_pixel(make_pixel(0, 1024, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
      send_pixel(make_pixel(2047, 2047, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF));
      send_pixel(make_pixel(-2048, -2048, 32'h0000_8000, 32'h0002_0000, 32'h00FF_0000));
      send_pixel(make_pixel(1023, 0, 32'h0000_00FF, 32'h0000_0100, 32'h7FFF_0000));
      send_pixel(make_pixel(0, 1023, 32'h1234_5678, 32'h0000_0002, 32'h0000_0003));
   endtask

   // register extremes: zero, one and above the limit (saturated)
   task automatic test_frame_settings();
      write_frame_reg(CSR_FRAME_WIDTH, 11'd0);
      write_frame_reg(CSR_FRAME_HEIGHT, 11'd1);
      send_pixel(make_pixel(0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
      write_frame_reg(CSR_FRAME_WIDTH, 11'd1);
      write_frame_reg(CSR_FRAME_HEIGHT, 11'd0);
      send_pixel(make_pixel(0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
      write_frame_reg(CSR_FRAME_HEIGHT, 11'd1);
      send_pixel(make_pixel(0, 0, 32'h0003_0000, 32'h0000_4000, 32'h0010_0000));
      send_pixel(make_pixel(1, 0, 32'h0003_0000, 32'h0000_4000, 32'h0010_0000));
      write_frame_reg(CSR_FRAME_WIDTH, 11'h7FF);
      write_frame_reg(CSR_FRAME_HEIGHT, 11'h7FF);
      send_pixel(make_pixel(1023, 1023, 32'h0003_0000, 32'h0000_4000, 32'h0010_0000));
      send_pixel(make_pixel(1024, 1023, 32'h0003_0000, 32'h0000_4000, 32'h0010_0000));
      send_pixel(make_pixel(2047, 0, 32'h0003_0000, 32'h0000_4000, 32'h0010_0000));
   endtask

   task automatic random_phase(input int idle_pct, input int count,
                               input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
      write_frame_reg(CSR_FRAME_WIDTH, w);
      write_frame_reg(CSR_FRAME_HEIGHT, h);
      sender_idle_pct = idle_pct;
      for (int i = 0; i < count; i++)
         send_pixel(rand_pixel($urandom_range(99, 0) < 80));
      sender_idle_pct = 0;
   endtask

   task automatic test_random_traffic();
      random_phase(0, 260, 11'd1024, 11'd1024);
      random_phase(64, 260, 11'($urandom_range(1024, 1)), 11'($urandom_range(1024, 1)));
      random_phase(0, 200, 11'd7, 11'd3);
      // wait until every pixel is out before resuming
      while (pixel_queue.size() != 0) @(negedge clock);
      random_phase(11, 200, 11'($urandom_range(2047, 1025)), 11'($urandom_range(64, 1)));
      random_phase(0, 100, 11'd1, 11'd1024);
   endtask

   initial begin
      mismatch_count  = 0;
      sender_idle_pct = 0;
      width_shadow    = FRAME_WIDTH_RESET;
      height_shadow   = FRAME_HEIGHT_RESET;
      reset           = 1'b1;
      start           = 1'b0;
      req_data        = '0;
      csr_valid       = 1'b0;
      csr_index       = CSR_FRAME_WIDTH;
      csr_data        = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_extremes();
      test_frame_settings();
      test_random_traffic();
      drain_pipe();
      if (mismatch_count == 0 && pixel_queue.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/htm_pkg.sv
hw/rtl/hdr_tone_map_pixel_writer_top.sv
bench/hdr_tone_map_pixel_writer_top_tb.sv
